// File: sv/utrd_pkg.sv
// shared types, constants and symbol lookup for the radix digit converter
package utrd_pkg;

    localparam int MAX_SYMBOLS_DEF = 40;
    localparam int VALUE_WIDTH_DEF = 64;

    // bits of the dividend consumed per divider cycle
    localparam int STEP_BITS = 8;

    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;
    localparam int IN_W          = 64;
    localparam int SYM_W         = 8;
    localparam int RADIX_W       = 6;
    localparam int NUM_SYM_REGS  = 5;
    localparam int NUM_SYM_BYTES = NUM_SYM_REGS * DATA_W / SYM_W;
    localparam int SYM_IDX_W     = 6;

    localparam logic [SYM_W-1:0]   ZERO_CHAR   = 8'h30;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;

    typedef enum logic [2:0] {
        REG_RADIX     = 3'd0,
        REG_SYM_FIRST = 3'd1,
        REG_SYM_LAST  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_DIV,
        S_RD,
        S_OUT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic last;
    } t_div_stat;

    typedef logic [NUM_SYM_REGS*DATA_W-1:0] t_sym_flat;

    function automatic logic [SYM_W-1:0] sym_byte(input t_sym_flat flat,
                                                  input logic [SYM_IDX_W-1:0] idx);
        logic [NUM_SYM_REGS*DATA_W-1:0] sh;
        sh = flat >> {idx, 3'b000};
        if (idx >= SYM_IDX_W'(NUM_SYM_BYTES)) begin
            return '0;
        end
        return sh[SYM_W-1:0];
    endfunction

endpackage

// File: sv/utrd_ram.sv
// generic single write port ram with registered read
module utrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/utrd_divider.sv
// iterative divider by a small radix, a few dividend bits per cycle
module utrd_divider #(
    parameter int QW = 64,
    parameter int DW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [QW-1:0]       i_value,
    input  logic [DW:0]         i_radix,
    output utrd_pkg::t_div_stat o_stat,
    output logic [DW-1:0]       o_digit
);
    import utrd_pkg::*;

    localparam int NSTEP = QW / STEP_BITS;
    localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic            r_busy, n_busy;
    logic [SCW-1:0]  r_step, n_step;
    logic [QW-1:0]   r_q, n_q;
    logic [DW-1:0]   r_rem, n_rem;
    logic [STEP_BITS-1:0] qbits;
    logic [DW-1:0]   rem_c;
    logic [DW:0]     trial;
    logic            step_last;

    // restoring long division, msb first, remainder stays below the radix
    always_comb begin
        rem_c = r_rem;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_c, r_q[QW-1-i]};
            if (trial >= i_radix) begin
                trial                  = trial - i_radix;
                qbits[STEP_BITS-1-i]   = 1'b1;
            end
            rem_c = trial[DW-1:0];
        end
    end

    assign step_last = (r_step == SCW'(NSTEP - 1));

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_q    = i_value;
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = (r_q << STEP_BITS) | QW'(qbits);
            n_rem = rem_c;
            if (step_last) begin
                // next digit starts from the fresh quotient
                n_step = '0;
                n_rem  = '0;
                if (n_q == '0) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_stat.done = r_busy && step_last;
    assign o_stat.last = (((r_q << STEP_BITS) | QW'(qbits)) == '0);
    assign o_digit     = rem_c;

endmodule

// File: sv/unsigned_to_radix_digits.sv
// top level: unsigned value to radix digits, most significant first
// a nonzero value is divided one digit at a time, each digit stored in the digit stack ram,
// then the digits are read back through the read and output states, most significant first
// zero skips the divider and gives its single result; one value is converted at a time
// reset is synchronous, active low: clears the sequencer, output valid, radix to 2
// and the symbols to 0; the digit stack is not cleared
module unsigned_to_radix_digits #(
    parameter int MAX_SYMBOLS = utrd_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_WIDTH = utrd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [utrd_pkg::IN_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [utrd_pkg::SYM_W-1:0]  o_symbol,
    output logic                        o_last_digit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [utrd_pkg::ADDR_W-1:0] paddr,
    input  logic [utrd_pkg::DATA_W-1:0] pwdata,
    output logic [utrd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import utrd_pkg::*;

    localparam int DW = $clog2(MAX_SYMBOLS);
    localparam int RW = DW + 1;
    localparam int QW = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_o_valid, n_o_valid;
    logic [SYM_W-1:0]    r_o_symbol, n_o_symbol;
    logic                r_o_last, n_o_last;
    logic [RADIX_W-1:0]  r_radix;
    logic [DATA_W-1:0]   r_sym [NUM_SYM_REGS];

    logic [2:0]          reg_idx;
    logic [2:0]          sym_sel;
    logic                wr_en;
    logic [RADIX_W:0]    radix_clamp;
    logic [RW-1:0]       eff_radix;
    logic [QW-1:0]       in_val;
    logic                div_start;
    t_div_stat           div_stat;
    logic [DW-1:0]       div_digit;
    logic                st_we;
    logic [DW-1:0]       st_rdata;
    logic [CW-1:0]       rd_ptr;
    logic                slot_free;
    t_sym_flat           sym_flat;

    // configuration port
    assign reg_idx = paddr[5:3];
    assign sym_sel = reg_idx - REG_SYM_FIRST;
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            for (int i = 0; i < NUM_SYM_REGS; i++) begin
                r_sym[i] <= '0;
            end
        end else if (wr_en) begin
            if (reg_idx == REG_RADIX) begin
                r_radix <= pwdata[RADIX_W-1:0];
            end else if (reg_idx >= REG_SYM_FIRST && reg_idx <= REG_SYM_LAST) begin
                r_sym[sym_sel] <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_RADIX) begin
            prdata = DATA_W'(r_radix);
        end else if (reg_idx >= REG_SYM_FIRST && reg_idx <= REG_SYM_LAST) begin
            prdata = r_sym[sym_sel];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SYM_REGS; i++) begin
            sym_flat[i*DATA_W +: DATA_W] = r_sym[i];
        end
    end

    // radix below two acts as two, above the alphabet as the alphabet size
    always_comb begin
        radix_clamp = {1'b0, r_radix};
        if (r_radix < RADIX_MIN) begin
            radix_clamp = {1'b0, RADIX_MIN};
        end else if ({1'b0, r_radix} > (RADIX_W+1)'(MAX_SYMBOLS)) begin
            radix_clamp = (RADIX_W+1)'(MAX_SYMBOLS);
        end
    end
    assign eff_radix = radix_clamp[RW-1:0];

    assign in_val    = QW'(i_value[VALUE_WIDTH-1:0]);
    assign o_ready   = (r_state == S_IDLE);
    assign div_start = i_valid && o_ready && (in_val != '0);

    utrd_divider #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (in_val),
        .i_radix (eff_radix),
        .o_stat  (div_stat),
        .o_digit (div_digit)
    );

    // digit stack, least significant digit at the bottom
    assign st_we  = (r_state == S_DIV) && div_stat.done;
    assign rd_ptr = r_cnt - 1'b1;

    utrd_ram #(
        .WIDTH (DW),
        .DEPTH (VALUE_WIDTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (div_digit),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (st_rdata)
    );

    assign slot_free = !r_o_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_symbol = r_o_symbol;
        n_o_last   = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cnt = '0;
                    if (in_val == '0) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_ZERO: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_symbol = ZERO_CHAR;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_cnt = r_cnt + 1'b1;
                    if (div_stat.last) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_symbol = sym_byte(sym_flat, SYM_IDX_W'(st_rdata));
                    n_o_last   = (r_cnt == CW'(1));
                    n_cnt      = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_o_symbol <= n_o_symbol;
        r_o_last   <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_symbol     = r_o_symbol;
    assign o_last_digit = r_o_last;

endmodule

// File: verif/unsigned_to_radix_digits_tb.sv
// testbench for unsigned_to_radix_digits: directed table, then random values checked by a digit predictor
`timescale 1ns / 100ps

module unsigned_to_radix_digits_tb;
    import utrd_pkg::*;

    localparam int RST_CYCLES      = 10;
    localparam int STALL_LIMIT     = 5000;
    localparam int END_CYCLES      = 700;
    localparam int HOLD_CYCLES     = 200;
    localparam int IDLE_PCT        = 27;
    localparam int N_PHASES        = 5;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int REG_SPARE_A     = 6;
    localparam int REG_SPARE_B     = 7;
    localparam int STACK_DEPTH     = 64;
    localparam int N_DIR           = 36;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_digit;
    } t_digit;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SEND,
        ROW_SEND_ONE
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        int               reg_idx;
        logic [63:0]      data;
        logic [SYM_W-1:0] one_sym;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [IN_W-1:0]   i_value;
    logic              o_valid;
    logic              i_ready;
    logic [SYM_W-1:0]  o_symbol;
    logic              o_last_digit;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // shadow of the configuration registers
    logic [RADIX_W-1:0] radix_sh;
    logic [DATA_W-1:0]  sym_sh [NUM_SYM_REGS];

    t_digit digit_q [$];
    int     err_count;
    int     quiet_cycles;
    bit     in_idle_en;
    bit     out_idle_en;
    bit     hold_req;
    int     hold_left;

    t_row dir_rows [N_DIR] = '{
        '{ROW_SEND_ONE, 0, 64'd0, ZERO_CHAR},
        '{ROW_SEND_ONE, 0, 64'd1, 8'h00},
        '{ROW_SEND, 0, '1, 8'h00},
        '{ROW_WRITE, 1, 64'h3736_3534_3332_3130, 8'h00},
        '{ROW_SEND_ONE, 0, 64'd1, 8'h31},
        '{ROW_SEND, 0, '1, 8'h00},
        '{ROW_SEND, 0, 64'h8000_0000_0000_0000, 8'h00},
        '{ROW_WRITE, 0, 64'd0, 8'h00},
        '{ROW_SEND, 0, 64'd5, 8'h00},
        '{ROW_WRITE, 0, 64'd1, 8'h00},
        '{ROW_SEND, 0, 64'd6, 8'h00},
        '{ROW_WRITE, 2, 64'h4645_4443_4241_3938, 8'h00},
        '{ROW_WRITE, 0, 64'd16, 8'h00},
        '{ROW_SEND, 0, 64'hDEAD_BEEF_0123_4567, 8'h00},
        '{ROW_SEND_ONE, 0, 64'd15, 8'h46},
        '{ROW_WRITE, 3, 64'h4E4D_4C4B_4A49_4847, 8'h00},
        '{ROW_WRITE, 4, 64'h5655_5453_5251_504F, 8'h00},
        '{ROW_WRITE, 5, 64'h6463_6261_5A59_5857, 8'h00},
        '{ROW_WRITE, 0, 64'd40, 8'h00},
        '{ROW_SEND_ONE, 0, 64'd39, 8'h64},
        '{ROW_SEND, 0, '1, 8'h00},
        '{ROW_SEND, 0, 64'd40, 8'h00},
        '{ROW_WRITE, 0, 64'd63, 8'h00},
        '{ROW_SEND_ONE, 0, 64'd39, 8'h64},
        '{ROW_SEND, 0, '1, 8'h00},
        '{ROW_WRITE, 0, 64'd41, 8'h00},
        '{ROW_SEND, 0, 64'd12345, 8'h00},
        '{ROW_WRITE, REG_SPARE_A, '1, 8'h00},
        '{ROW_WRITE, REG_SPARE_B, 64'd0, 8'h00},
        '{ROW_SEND, 0, 64'd1600, 8'h00},
        '{ROW_WRITE, 1, '1, 8'h00},
        '{ROW_WRITE, 0, 64'd8, 8'h00},
        '{ROW_SEND, 0, 64'h0123_4567_89AB_CDEF, 8'h00},
        // zero ignores the alphabet
        '{ROW_SEND_ONE, 0, 64'd0, ZERO_CHAR},
        '{ROW_WRITE, 0, 64'd3, 8'h00},
        '{ROW_SEND, 0, '1, 8'h00}
    };

    unsigned_to_radix_digits i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_symbol     (o_symbol),
        .o_last_digit (o_last_digit),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // expected digit symbols of one value, most significant first
    function automatic void push_digits(input logic [IN_W-1:0] value);
        logic [IN_W-1:0]      quo;
        logic [IN_W-1:0]      base;
        logic [SYM_IDX_W-1:0] stack [STACK_DEPTH];
        logic [SYM_IDX_W-1:0] idx;
        int                   n;
        t_digit               d;
        base = IN_W'(radix_sh);
        if (base < IN_W'(RADIX_MIN)) begin
            base = IN_W'(RADIX_MIN);
        end
        if (base > IN_W'(MAX_SYMBOLS_DEF)) begin
            base = IN_W'(MAX_SYMBOLS_DEF);
        end
        quo = value;
        n   = 0;
        if (quo == '0) begin
            d.symbol     = ZERO_CHAR;
            d.last_digit = 1'b1;
            digit_q.push_back(d);
            return;
        end
        while (quo != '0 && n < STACK_DEPTH) begin
            stack[n] = SYM_IDX_W'(quo % base);
            quo      = quo / base;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            idx = stack[k];
            if ((idx >> 3) >= NUM_SYM_REGS) begin
                d.symbol = '0;
            end else begin
                d.symbol = sym_sh[idx >> 3][idx[2:0]*SYM_W +: SYM_W];
            end
            d.last_digit = (k == 0);
            digit_q.push_back(d);
        end
    endfunction

    // one register access, setup then access phase; reads compare against the shadow
    task automatic reg_access(input bit wr, input int idx, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] want;
        want    = (idx == int'(REG_RADIX)) ? DATA_W'(radix_sh)
                                            : sym_sh[idx - int'(REG_SYM_FIRST)];
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = ADDR_W'(idx * 8);
        pwdata  = wr ? data : '0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!wr && prdata !== want) begin
            $error("prdata[%0d]: expected 0x%016h, got 0x%016h", idx, want, prdata);
            err_count++;
        end
        if (wr && idx == int'(REG_RADIX)) begin
            radix_sh = data[RADIX_W-1:0];
        end else if (wr && idx >= int'(REG_SYM_FIRST) && idx <= int'(REG_SYM_LAST)) begin
            sym_sh[idx - int'(REG_SYM_FIRST)] = data;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // offer one value and record its digits once the request is taken
    task automatic send_value(input logic [IN_W-1:0] value, input bit one,
                              input logic [SYM_W-1:0] one_sym);
        t_digit d;
        while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (one) begin
            d.symbol     = one_sym;
            d.last_digit = 1'b1;
            digit_q.push_back(d);
        end else begin
            push_digits(value);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (digit_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready = 1'b0;
        end else if (hold_left != 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_ready   = 1'b0;
        end else begin
            i_ready = !(out_idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_valid && i_ready) begin
            if (digit_q.size() == 0) begin
                $error("symbol 0x%02h with no request pending", o_symbol);
                err_count++;
            end else begin
                want = digit_q.pop_front();
                if (o_symbol !== want.symbol) begin
                    $error("symbol: expected 0x%02h, got 0x%02h", want.symbol, o_symbol);
                    err_count++;
                end
                if (o_last_digit !== want.last_digit) begin
                    $error("last_digit: expected %0b, got %0b", want.last_digit,
                           o_last_digit);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0]    v;
        logic [RADIX_W-1:0] r;
        int                 w;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = '0;
        i_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        err_count    = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        hold_left    = 0;
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        radix_sh     = RADIX_RESET;
        foreach (sym_sh[i]) sym_sh[i] = '0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: begin
                    wait_drained();
                    reg_access(1'b1, dir_rows[i].reg_idx, dir_rows[i].data);
                end
                ROW_SEND: begin
                    send_value(dir_rows[i].data, 1'b0, '0);
                end
                default: begin
                    send_value(dir_rows[i].data, 1'b1, dir_rows[i].one_sym);
                end
            endcase
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            // phase one runs with no stalls on either side
            in_idle_en  = (ph != 1);
            out_idle_en = (ph != 1);
            r = ($urandom_range(99) < 80) ? RADIX_W'($urandom_range(2, 40))
                                          : RADIX_W'($urandom_range(0, 63));
            reg_access(1'b1, int'(REG_RADIX), DATA_W'(r));
            for (int k = int'(REG_SYM_FIRST); k <= int'(REG_SYM_LAST); k++) begin
                reg_access(1'b1, k, {$urandom, $urandom});
            end
            for (int k = int'(REG_RADIX); k <= int'(REG_SYM_LAST); k++) begin
                reg_access(1'b0, k, '0);
            end
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                w = $urandom_range(1, 64);
                v = {$urandom, $urandom};
                if (w < 64) begin
                    v = v & ((64'd1 << w) - 64'd1);
                end
                if ($urandom_range(11) == 0) begin
                    v = '0;
                end
                send_value(v, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (err_count == 0 && digit_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
